/* src/dmc_pkg.sv */
// ----------------------------------------------------------------------------
// dmc_pkg
// Shared types and constants of the depth-first maze carver.
// ----------------------------------------------------------------------------
package dmc_pkg;

    localparam int unsigned SIDE       = 64;
    localparam int unsigned CW         = 6;
    localparam int unsigned HALF_W     = CW - 1;
    localparam int unsigned NODE_AW    = 2 * HALF_W;
    localparam int unsigned NODE_DEPTH = 1 << NODE_AW;
    localparam int unsigned NODE_W     = 7;

    localparam logic [3:0] DIRS_ALL = 4'hF;

    localparam logic CFG_WIDTH  = 1'b0;
    localparam logic CFG_HEIGHT = 1'b1;

    typedef enum logic [1:0] {
        CMD_INIT  = 2'd0,
        CMD_CARVE = 2'd1,
        CMD_READ  = 2'd2
    } t_cmd;

    typedef enum logic [1:0] {
        DIR_RIGHT = 2'd0,
        DIR_DOWN  = 2'd1,
        DIR_LEFT  = 2'd2,
        DIR_UP    = 2'd3
    } t_dir;

    typedef enum logic [3:0] {
        ST_CARVED    = 4'd0,
        ST_TRIED     = 4'd1,
        ST_EDGE      = 4'd2,
        ST_VISITED   = 4'd3,
        ST_BACKTRACK = 4'd4,
        ST_FINISHED  = 4'd5,
        ST_READ      = 4'd6,
        ST_SIZE_ERR  = 4'd7,
        ST_INIT_DONE = 4'd8
    } t_status;

    typedef struct packed {
        t_status       status;
        logic          is_wall;
        logic [CW-1:0] pos_x;
        logic [CW-1:0] pos_y;
    } t_result;

    typedef enum logic [4:0] {
        S_PASS = 5'b00001,
        S_IDLE = 5'b00010,
        S_HERE = 5'b00100,
        S_TGT  = 5'b01000,
        S_RD   = 5'b10000
    } t_state;

endpackage

/* src/dfs_maze_carver.sv */
// ----------------------------------------------------------------------------
// dfs_maze_carver
// Recursive backtracker maze generator with node and wall memories.
// ----------------------------------------------------------------------------
// After reset the block runs a clearing pass over node memory (and the 64
// wall rows) with s_axis_tready low. Init runs the same pass; a size error
// answers without one. A carve step that ends on the current node (tried,
// edge, backtrack) reads only the current node, and one that reaches the
// target (carved, visited) also reads the target node; a carve after finish
// reads neither. A read reads one wall row. The node memory has a registered
// read port. One result transaction may wait in the output register while
// the next item is being worked on.
module dfs_maze_carver
    import dmc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [5:0]  i_cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // command[1:0], rand_draw[3:2], cell_x[9:4], cell_y[15:10]
    input  logic [15:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // status[3:0], is_wall[4], pos_x[10:5], pos_y[16:11], zero[23:17]
    output logic [23:0] m_axis_tdata
);

    logic [NODE_W-1:0] r_node_mem [NODE_DEPTH];
    logic [SIDE-1:0]   r_wall_mem [SIDE];
    logic [NODE_W-1:0] r_node_rd;
    logic [SIDE-1:0]   r_wall_rd;

    logic              node_we, wall_we;
    logic [NODE_AW-1:0] node_wa, node_ra;
    logic [NODE_W-1:0] node_wd;
    logic [CW-1:0]     wall_wa, wall_ra;
    logic [SIDE-1:0]   wall_wd;

    t_state            r_state, n_state;
    logic [NODE_AW-1:0] r_cnt, n_cnt;
    logic              r_init, n_init;
    logic [CW-1:0]     r_cur_x, n_cur_x, r_cur_y, n_cur_y;
    logic              r_fin, n_fin;
    logic              r_res_v, n_res_v;
    t_result           r_res, n_res;
    logic              r_ov, n_ov;
    t_result           r_out, n_out;
    logic [CW-1:0]     r_w, r_h;
    logic [1:0]        r_draw, n_draw;
    logic [CW-1:0]     r_rx, n_rx, r_ry, n_ry;
    logic [CW-1:0]     r_tx, n_tx, r_ty, n_ty;
    logic [CW-1:0]     r_wx, n_wx, r_wy, n_wy;

    logic              accept, move;
    logic [1:0]        in_cmd, in_draw;
    logic [CW-1:0]     in_x, in_y;
    logic              size_ok;
    logic [CW:0]       tx7, ty7;
    logic              tgt_ok;
    logic [CW-1:0]     wx, wy, px, py;
    logic [CW-1:0]     pass_row;
    logic [SIDE-1:0]   pass_mask;
    logic [3:0]        here_bit;

    assign in_cmd  = s_axis_tdata[1:0];
    assign in_draw = s_axis_tdata[3:2];
    assign in_x    = s_axis_tdata[9:4];
    assign in_y    = s_axis_tdata[15:10];

    assign move   = r_res_v && (!r_ov || m_axis_tready);
    assign s_axis_tready = (r_state == S_IDLE) && (!r_res_v || move);
    assign accept = s_axis_tvalid && s_axis_tready;

    assign size_ok = r_w[0] && (r_w >= CW'(3)) && r_h[0] && (r_h >= CW'(3));
    assign here_bit = 4'(1) << r_draw;

    // target node and the wall cell between
    always_comb begin
        tx7    = {1'b0, r_cur_x};
        ty7    = {1'b0, r_cur_y};
        wx     = r_cur_x;
        wy     = r_cur_y;
        tgt_ok = 1'b0;
        case (t_dir'(r_draw))
            DIR_RIGHT: begin
                tx7    = {1'b0, r_cur_x} + (CW+1)'(2);
                wx     = r_cur_x + CW'(1);
                tgt_ok = tx7 < {1'b0, r_w};
            end
            DIR_DOWN: begin
                ty7    = {1'b0, r_cur_y} + (CW+1)'(2);
                wy     = r_cur_y + CW'(1);
                tgt_ok = ty7 < {1'b0, r_h};
            end
            DIR_LEFT: begin
                tx7    = {1'b0, r_cur_x} - (CW+1)'(2);
                wx     = r_cur_x - CW'(1);
                tgt_ok = r_cur_x >= CW'(2);
            end
            default: begin
                ty7    = {1'b0, r_cur_y} - (CW+1)'(2);
                wy     = r_cur_y - CW'(1);
                tgt_ok = r_cur_y >= CW'(2);
            end
        endcase
    end

    // parent of the current node
    always_comb begin
        px = r_cur_x;
        py = r_cur_y;
        case (t_dir'(r_node_rd[6:5]))
            DIR_RIGHT: px = r_cur_x - CW'(2);
            DIR_DOWN:  py = r_cur_y - CW'(2);
            DIR_LEFT:  px = r_cur_x + CW'(2);
            default:   py = r_cur_y + CW'(2);
        endcase
    end

    // wall row built during a pass
    assign pass_row = r_cnt[NODE_AW-1 -: CW];
    always_comb begin
        for (int x = 0; x < SIDE; x++) begin
            pass_mask[x] = !(r_init && pass_row[0] && (pass_row < r_h) &&
                             (x % 2 == 1) && (CW'(x) < r_w));
        end
    end

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_init  = r_init;
        n_cur_x = r_cur_x;
        n_cur_y = r_cur_y;
        n_fin   = r_fin;
        n_res_v = r_res_v && !move;
        n_res   = r_res;
        n_ov    = r_ov && !m_axis_tready;
        n_out   = r_out;
        n_draw  = r_draw;
        n_rx    = r_rx;
        n_ry    = r_ry;
        n_tx    = r_tx;
        n_ty    = r_ty;
        n_wx    = r_wx;
        n_wy    = r_wy;
        node_we = 1'b0;
        node_wa = r_cnt;
        node_wd = {3'b000, DIRS_ALL};
        node_ra = {r_cur_y[CW-1:1], r_cur_x[CW-1:1]};
        wall_we = 1'b0;
        wall_wa = pass_row;
        wall_wd = pass_mask;
        wall_ra = in_y;

        if (move) begin
            n_ov  = 1'b1;
            n_out = r_res;
        end

        unique case (r_state)
            S_PASS: begin
                node_we = 1'b1;
                node_wa = r_cnt;
                node_wd = {2'b00, r_init && (r_cnt == '0), DIRS_ALL};
                wall_we = (r_cnt[NODE_AW-CW-1:0] == '0);
                n_cnt   = r_cnt + NODE_AW'(1);
                if (r_cnt == '1) begin
                    n_state = S_IDLE;
                    n_cur_x = CW'(1);
                    n_cur_y = CW'(1);
                    n_fin   = 1'b0;
                    if (r_init) begin
                        n_res_v = 1'b1;
                        n_res   = '{ST_INIT_DONE, 1'b0, CW'(1), CW'(1)};
                    end
                end
            end
            S_IDLE: begin
                if (accept) begin
                    n_draw = in_draw;
                    n_rx   = in_x;
                    n_ry   = in_y;
                    case (t_cmd'(in_cmd))
                        CMD_INIT: begin
                            if (size_ok) begin
                                n_state = S_PASS;
                                n_cnt   = '0;
                                n_init  = 1'b1;
                            end else begin
                                n_res_v = 1'b1;
                                n_res   = '{ST_SIZE_ERR, 1'b0, r_cur_x, r_cur_y};
                            end
                        end
                        CMD_CARVE: begin
                            if (r_fin) begin
                                n_res_v = 1'b1;
                                n_res   = '{ST_FINISHED, 1'b0, r_cur_x, r_cur_y};
                            end else begin
                                n_state = S_HERE;
                            end
                        end
                        default: n_state = S_RD;
                    endcase
                end
            end
            S_HERE: begin
                n_state = S_IDLE;
                n_res_v = 1'b1;
                if (r_node_rd[3:0] == '0) begin
                    if (r_cur_x == CW'(1) && r_cur_y == CW'(1)) begin
                        n_fin = 1'b1;
                        n_res = '{ST_FINISHED, 1'b0, r_cur_x, r_cur_y};
                    end else begin
                        n_cur_x = px;
                        n_cur_y = py;
                        if (px == CW'(1) && py == CW'(1)) begin
                            n_fin = 1'b1;
                            n_res = '{ST_FINISHED, 1'b0, px, py};
                        end else begin
                            n_res = '{ST_BACKTRACK, 1'b0, px, py};
                        end
                    end
                end else if ((r_node_rd[3:0] & here_bit) == '0) begin
                    n_res = '{ST_TRIED, 1'b0, r_cur_x, r_cur_y};
                end else begin
                    node_we = 1'b1;
                    node_wa = {r_cur_y[CW-1:1], r_cur_x[CW-1:1]};
                    node_wd = {r_node_rd[6:4], r_node_rd[3:0] & ~here_bit};
                    if (!tgt_ok) begin
                        n_res = '{ST_EDGE, 1'b0, r_cur_x, r_cur_y};
                    end else begin
                        n_res_v = 1'b0;
                        n_state = S_TGT;
                        n_tx    = tx7[CW-1:0];
                        n_ty    = ty7[CW-1:0];
                        n_wx    = wx;
                        n_wy    = wy;
                        node_ra = {ty7[CW-1:1], tx7[CW-1:1]};
                        wall_ra = wy;
                    end
                end
            end
            S_TGT: begin
                n_state = S_IDLE;
                n_res_v = 1'b1;
                if (r_node_rd[4]) begin
                    n_res = '{ST_VISITED, 1'b0, r_cur_x, r_cur_y};
                end else begin
                    node_we = 1'b1;
                    node_wa = {r_ty[CW-1:1], r_tx[CW-1:1]};
                    node_wd = {r_draw, 1'b1, r_node_rd[3:0]};
                    wall_we = 1'b1;
                    wall_wa = r_wy;
                    wall_wd = r_wall_rd & ~(SIDE'(1) << r_wx);
                    n_cur_x = r_tx;
                    n_cur_y = r_ty;
                    n_res   = '{ST_CARVED, 1'b0, r_tx, r_ty};
                end
            end
            S_RD: begin
                n_state = S_IDLE;
                n_res_v = 1'b1;
                n_res   = '{ST_READ,
                            (r_rx >= r_w) || (r_ry >= r_h) || r_wall_rd[r_rx],
                            r_cur_x, r_cur_y};
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (node_we) begin
            r_node_mem[node_wa] <= node_wd;
        end
        r_node_rd <= r_node_mem[node_ra];
    end

    always_ff @(posedge i_clk) begin
        if (wall_we) begin
            r_wall_mem[wall_wa] <= wall_wd;
        end
        r_wall_rd <= r_wall_mem[wall_ra];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_PASS;
            r_cnt   <= '0;
            r_init  <= 1'b0;
            r_cur_x <= CW'(1);
            r_cur_y <= CW'(1);
            r_fin   <= 1'b0;
            r_res_v <= 1'b0;
            r_ov    <= 1'b0;
            r_w     <= CW'(31);
            r_h     <= CW'(31);
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_init  <= n_init;
            r_cur_x <= n_cur_x;
            r_cur_y <= n_cur_y;
            r_fin   <= n_fin;
            r_res_v <= n_res_v;
            r_ov    <= n_ov;
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_WIDTH) begin
                    r_w <= i_cfg_data;
                end
                if (i_cfg_idx == CFG_HEIGHT) begin
                    r_h <= i_cfg_data;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_res  <= n_res;
        r_out  <= n_out;
        r_draw <= n_draw;
        r_rx   <= n_rx;
        r_ry   <= n_ry;
        r_tx   <= n_tx;
        r_ty   <= n_ty;
        r_wx   <= n_wx;
        r_wy   <= n_wy;
    end

    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata  = {7'b0, r_out.pos_y, r_out.pos_x, r_out.is_wall, r_out.status};

endmodule

/* src/dmc_checker.sv */
// ----------------------------------------------------------------------------
// dmc_checker
// Port-level checks of the maze carver, bound to the top level.
// ----------------------------------------------------------------------------
module dmc_checker
    import dmc_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [23:0] m_axis_tdata
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result transaction dropped or changed while stalled");

    a_wall_only_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[4] |-> m_axis_tdata[3:0] == ST_READ)
        else $error("wall bit set on a non-read result");

    a_pos_odd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[5] && m_axis_tdata[11])
        else $error("current node off the node lattice");

    a_init_home: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[3:0] == ST_INIT_DONE
        |-> m_axis_tdata[10:5] == 6'd1 && m_axis_tdata[16:11] == 6'd1)
        else $error("init did not return to the start node");

    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !s_axis_tready)
        else $error("input taken during the clearing pass");

endmodule

bind dfs_maze_carver dmc_checker u_dmc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
